// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the looper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define ALS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define ALS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/als_pkg.sv =====
// Package with the looper's field types, function codes and constants.
`default_nettype none

package als_pkg;

  localparam int unsigned ALS_STORE_DEPTH = 1048576;

  localparam int SAMPLE_W = 24;
  localparam int MIX_W    = 17;
  localparam int FUNC_W   = 2;

  localparam logic [MIX_W-1:0] MIX_UNITY = 17'h10000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_REC    = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_PLAY   = 2'd3
  } func_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MIX_W-1:0]           mix_t;

endpackage

`default_nettype wire

// ===== hdl/als_if.sv =====
// Valid/ready channel interfaces for the looper's input and result items.
`default_nettype none

interface als_in_if;
  import als_pkg::*;

  logic    valid;
  logic    ready;
  func_t   func;
  sample_t sample_in;
  mix_t    mix;

  modport source (output valid, output func, output sample_in, output mix, input ready);
  modport sink   (input valid, input func, input sample_in, input mix, output ready);
endinterface

interface als_out_if;
  import als_pkg::*;

  logic    valid;
  logic    ready;
  sample_t audio_out;
  logic    playing;
  logic    recording;

  modport source (output valid, output audio_out, output playing, output recording,
                  input ready);
  modport sink   (input valid, input audio_out, input playing, input recording,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/als_rem.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module als_rem #(
  parameter int unsigned LW = $clog2(als_pkg::ALS_STORE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [LW-1:0] dividend,
  input  logic [LW-1:0] divisor,
  output logic          done,
  output logic [LW-1:0] rem
);

  localparam int CW = $clog2(LW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [LW-1:0] dvd_r;
  logic [LW-1:0] dvs_r;
  logic [LW-1:0] rem_r;
  logic [LW:0]   shifted;
  logic [LW-1:0] rem_step;

  always_comb begin
    shifted = {rem_r, dvd_r[cnt_r]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_step = LW'(shifted - {1'b0, dvs_r});
    end else begin
      rem_step = shifted[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(LW - 1);
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // A zero divisor wraps to zero.
  assign rem  = (dvs_r == '0) ? '0 : rem_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== hdl/audio_looper_sound_on_sound.sv =====
// Top level of the sound-on-sound audio looper.
//
//  Channel   Dir  Payload                              Handshake
//  in_item   in   func, sample_in, mix                 valid/ready
//  out_item  out  audio_out, playing, recording        valid/ready
//
// A sample item takes three steps: the loop store read, then the averaging
// write-back and the two mix multiplies, then the sum into the output register,
// which waits while a stalled result is held. A record press that closes the
// first take also waits on the iterative wrap-around remainder unit.
// An armed hold-clear sweeps one store entry per cycle over the loop length.
// After reset the whole store is swept before any item is taken.
// A stalled result holds in the output register while the next item is accepted.
`default_nettype none
`include "assert_macros.svh"

module audio_looper_sound_on_sound #(
  parameter int unsigned STORE_DEPTH = als_pkg::ALS_STORE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  als_in_if.sink     in_item,
  als_out_if.source  out_item
);

  import als_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = $clog2(STORE_DEPTH + 1);
  localparam int PW = SAMPLE_W + MIX_W + 1;
  localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_EXEC = 6'b000100,
    S_DIV  = 6'b001000,
    S_CLR  = 6'b010000,
    S_MIX  = 6'b100000
  } state_t;

  sample_t mem [STORE_DEPTH];

  state_t        state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] npos_r, npos_nxt;
  logic          pend_r, pend_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] tc_r, tc_nxt;
  logic          first_r, first_nxt;
  logic          rec_r, rec_nxt;
  logic          play_r, play_nxt;
  logic          armed_r, armed_nxt;
  logic [LW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0] clr_end_r, clr_end_nxt;
  logic          out_valid_r, out_valid_nxt;
  sample_t       audio_r, audio_nxt;
  logic          playing_r, playing_nxt;
  logic          recording_r, recording_nxt;

  func_t         func_r;
  sample_t       sample_r;
  mix_t          mix_r;
  sample_t       rd_data_r;
  logic signed [PW-2:0] p_loop_r;
  logic signed [PW-2:0] p_live_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  sample_t       mem_wdata;
  logic signed [SAMPLE_W:0] avg_sum;
  sample_t       avg;
  sample_t       loop_val;
  mix_t          mix_sat;
  mix_t          live_w;
  logic [LW-1:0] tc_inc;
  logic [LW-1:0] pos_inc;
  logic signed [PW-1:0] acc;
  logic          rem_start;
  logic          rem_done;
  logic [LW-1:0] rem_val;

  als_rem #(
    .LW (LW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (pos_inc),
    .divisor  (tc_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  always_comb begin
    avg_sum  = (SAMPLE_W + 1)'(rd_data_r) + (SAMPLE_W + 1)'(sample_r);
    avg      = avg_sum[SAMPLE_W:1];
    loop_val = rec_r ? avg : rd_data_r;
    mix_sat  = (mix_r > MIX_UNITY) ? MIX_UNITY : mix_r;
    live_w   = MIX_UNITY - mix_sat;
    pos_inc  = LW'(pos_r) + LW'(1);
    acc      = PW'(p_loop_r) + PW'(p_live_r);
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    npos_nxt      = npos_r;
    pend_nxt      = pend_r;
    len_nxt       = len_r;
    tc_nxt        = tc_r;
    first_nxt     = first_r;
    rec_nxt       = rec_r;
    play_nxt      = play_r;
    armed_nxt     = armed_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_end_nxt   = clr_end_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    audio_nxt     = audio_r;
    playing_nxt   = playing_r;
    recording_nxt = recording_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = avg;
    rem_start     = 1'b0;
    tc_inc        = tc_r;

    unique case (state_r)
      S_INIT, S_CLR: begin
        if (clr_cnt_r == clr_end_r) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_MIX;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = clr_cnt_r[AW-1:0];
          mem_wdata   = '0;
          clr_cnt_nxt = clr_cnt_r + LW'(1);
        end
      end
      S_IDLE: begin
        if (in_item.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_MIX;
        case (func_r)
          FUNC_SAMPLE: begin
            if (rec_r) begin
              mem_we = 1'b1;
              if (first_r) begin
                tc_inc = tc_r + LW'(1);
              end
            end
            tc_nxt = tc_inc;
            if (tc_inc >= DEPTH_L) begin
              first_nxt = 1'b0;
              len_nxt   = DEPTH_L;
              tc_nxt    = '0;
            end
            if (play_r) begin
              if (pend_r) begin
                pos_nxt  = npos_r;
                pend_nxt = 1'b0;
              end else if (pos_inc >= len_r) begin
                pos_nxt = '0;
              end else begin
                pos_nxt = pos_inc[AW-1:0];
              end
            end
          end
          FUNC_REC: begin
            if (first_r && rec_r) begin
              first_nxt = 1'b0;
              len_nxt   = tc_r;
              tc_nxt    = '0;
              rem_start = 1'b1;
              state_nxt = S_DIV;
            end
            armed_nxt = 1'b1;
            play_nxt  = 1'b1;
            rec_nxt   = !rec_r;
          end
          FUNC_CLEAR: begin
            if (armed_r) begin
              play_nxt    = 1'b0;
              rec_nxt     = 1'b0;
              first_nxt   = 1'b1;
              pos_nxt     = '0;
              tc_nxt      = '0;
              pend_nxt    = 1'b0;
              len_nxt     = DEPTH_L;
              armed_nxt   = 1'b0;
              clr_cnt_nxt = '0;
              clr_end_nxt = len_r;
              state_nxt   = S_CLR;
            end
          end
          default: begin
            play_nxt = !play_r;
          end
        endcase
      end
      S_DIV: begin
        if (rem_done) begin
          npos_nxt  = rem_val[AW-1:0];
          pend_nxt  = 1'b1;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt = 1'b1;
          audio_nxt     = (func_r == FUNC_SAMPLE) ? acc[SAMPLE_W+15:16] : '0;
          playing_nxt   = play_r;
          recording_nxt = rec_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      len_r       <= DEPTH_L;
      tc_r        <= '0;
      first_r     <= 1'b1;
      rec_r       <= 1'b0;
      play_r      <= 1'b0;
      armed_r     <= 1'b0;
      clr_cnt_r   <= '0;
      clr_end_r   <= DEPTH_L;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      len_r       <= len_nxt;
      tc_r        <= tc_nxt;
      first_r     <= first_nxt;
      rec_r       <= rec_nxt;
      play_r      <= play_nxt;
      armed_r     <= armed_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_end_r   <= clr_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    npos_r      <= npos_nxt;
    audio_r     <= audio_nxt;
    playing_r   <= playing_nxt;
    recording_r <= recording_nxt;
    if (state_r == S_IDLE && in_item.valid) begin
      func_r   <= in_item.func;
      sample_r <= in_item.sample_in;
      mix_r    <= in_item.mix;
    end
    if (state_r == S_EXEC) begin
      p_loop_r <= loop_val * $signed({1'b0, mix_sat});
      p_live_r <= sample_r * $signed({1'b0, live_w});
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[pos_r];
  end

  assign in_item.ready      = (state_r == S_IDLE);
  assign out_item.valid     = out_valid_r;
  assign out_item.audio_out = audio_r;
  assign out_item.playing   = playing_r;
  assign out_item.recording = recording_r;

  `ALS_ASSERT_IMP(a_pend_not_first, clk, rst_n, pend_r, !first_r,
                  "Wrap pending during a first take")
  `ALS_ASSERT_IMP(a_first_full_len, clk, rst_n, first_r, len_r == DEPTH_L,
                  "First take without full loop length")
  `ALS_ASSERT_IMP(a_pos_in_loop, clk, rst_n, (state_r == S_IDLE) && !pend_r,
                  (LW'(pos_r) < len_r) || ((len_r == '0) && (pos_r == '0)),
                  "Play position beyond loop length")
  `ALS_ASSERT_IMP(a_out_from_mix, clk, rst_n, $rose(out_item.valid),
                  $past(state_r == S_MIX), "Result raised outside the mix stage")

endmodule

`default_nettype wire
